// File: design/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and constants of the length-prefixed status packet parser
// Holds the parser phases, the command codes and the item passed from the front
// part to the back part.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int MaxPayloadDefault = 16;
   localparam int StoreBytesDefault = 64;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_DATA   = 2'd2,
      PH_DRAIN  = 2'd3
   } phase_type;

   localparam logic [6:0] CMD_POLL  = 7'd0;
   localparam logic [6:0] CMD_KEY   = 7'd1;
   localparam logic [6:0] CMD_CURS  = 7'd2;
   localparam logic [6:0] CMD_CHAR  = 7'd3;
   localparam logic [6:0] CMD_PIXEL = 7'd4;
   localparam logic [6:0] CMD_AUDIO = 7'd5;
   localparam logic [6:0] CMD_MODE  = 7'd6;
   localparam logic [6:0] CMD_CLOCK = 7'd7;
   localparam logic [6:0] CMD_KBD   = 7'd8;

   localparam logic [7:0] FLAG_CHAR  = 8'h02;
   localparam logic [7:0] FLAG_PIXEL = 8'h04;
   localparam logic [7:0] FLAG_AUDIO = 8'h08;
   localparam logic [7:0] FLAG_MODE  = 8'h10;
   localparam logic [7:0] FLAG_CLOCK = 8'h20;

   localparam logic [7:0] VK_BS  = 8'h08;
   localparam logic [7:0] VK_DEL = 8'h7F;

   // work handed to the back part: a read, or a completed packet
   typedef struct packed {
      logic       is_pkt;
      logic [7:0] roff;
      logic [6:0] cmd;
      logic [7:0] len;
      logic [7:0][7:0] d;
   } work_type;

endpackage

// File: design/lsp_front.sv
// ----------------------------------------------------------------------------
// lsp_front: byte parser
// Tracks header, length, payload and drain phases, collects payload bytes and
// emits one work item per read access or completed packet.
// ----------------------------------------------------------------------------
module lsp_front #(
   parameter int MAX_PAYLOAD = lsp_pkg::MaxPayloadDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [7:0]        req_rx_byte,
   input  logic [5:0]        req_read_offset,
   output logic              wk_valid,
   input  logic              wk_ready,
   output lsp_pkg::work_type wk_data
);
   localparam int BW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   lsp_pkg::phase_type phase_ff, phase_in;
   logic [6:0] cmd_ff, cmd_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] seen_ff, seen_in;
   // only the first eight bytes are ever used by a command
   logic [7:0][7:0] buf_ff;
   logic       acc;
   logic [7:0] seen_p1;

   assign req_ready = wk_ready;
   assign acc = req_valid && req_ready;
   assign seen_p1 = seen_ff + 8'd1;

   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      wk_valid = 1'b0;
      wk_data.is_pkt = 1'b0;
      wk_data.roff = {2'b00, req_read_offset};
      wk_data.cmd = cmd_ff;
      wk_data.len = len_ff;
      wk_data.d = buf_ff;
      if (seen_ff < 8'd8) begin
         wk_data.d[seen_ff[2:0]] = req_rx_byte;
      end
      if (req_valid && req_func) begin
         wk_valid = 1'b1;
      end else if (req_valid) begin
         case (phase_ff)
            lsp_pkg::PH_HEADER: begin
               if (req_rx_byte[7]) begin
                  cmd_in = req_rx_byte[6:0];
                  len_in = '0;
                  seen_in = '0;
                  phase_in = lsp_pkg::PH_LENGTH;
               end
            end
            lsp_pkg::PH_LENGTH: begin
               len_in = req_rx_byte;
               if (req_rx_byte == 8'd0) begin
                  phase_in = lsp_pkg::PH_HEADER;
                  cmd_in = '0;
               end else if (req_rx_byte > 8'(MAX_PAYLOAD)) begin
                  phase_in = lsp_pkg::PH_DRAIN;
               end else begin
                  phase_in = lsp_pkg::PH_DATA;
               end
            end
            lsp_pkg::PH_DRAIN: begin
               seen_in = seen_p1;
               if (seen_p1 >= len_ff) begin
                  phase_in = lsp_pkg::PH_HEADER;
                  cmd_in = '0; len_in = '0; seen_in = '0;
               end
            end
            lsp_pkg::PH_DATA: begin
               seen_in = seen_p1;
               if (seen_p1 >= len_ff) begin
                  wk_valid = 1'b1;
                  wk_data.is_pkt = 1'b1;
                  phase_in = lsp_pkg::PH_HEADER;
                  cmd_in = '0; len_in = '0; seen_in = '0;
               end
            end
            default: phase_in = lsp_pkg::PH_HEADER;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lsp_pkg::PH_HEADER;
         cmd_ff <= '0;
         len_ff <= '0;
         seen_ff <= '0;
      end else if (acc) begin
         phase_ff <= phase_in;
         cmd_ff <= cmd_in;
         len_ff <= len_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && !req_func && phase_ff == lsp_pkg::PH_DATA && seen_ff < 8'd8
          && seen_ff < 8'(1 << BW) + 8'd8) begin
         buf_ff[seen_ff[2:0]] <= req_rx_byte;
      end
   end

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_ready == wk_ready) else $error("ready not tied to queue space");
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lsp_pkg::PH_DATA |-> len_ff != 8'd0 && len_ff <= 8'(MAX_PAYLOAD))
      else $error("payload phase with bad length");
   a_read_issues: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_func |-> wk_valid && !wk_data.is_pkt)
      else $error("read access not issued");
endmodule

// File: design/lsp_queue.sv
// ----------------------------------------------------------------------------
// lsp_queue: two-entry work queue
// Parts the parser from the store update so either side can stall.
// ----------------------------------------------------------------------------
module lsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  lsp_pkg::work_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output lsp_pkg::work_type out_data
);
   lsp_pkg::work_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue overflow");
   a_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff)
      else $error("queue pointers out of step");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 2'd1) else $error("pop lost");
endmodule

// File: design/lsp_back.sv
// ----------------------------------------------------------------------------
// lsp_back: status store update and result register
// Applies a completed packet to the status store at once, or reads one
// byte of it, and holds the result for the receiver.
// ----------------------------------------------------------------------------
module lsp_back #(
   parameter int STORE_BYTES = lsp_pkg::StoreBytesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        poll_echo,
   input  logic              wk_valid,
   output logic              wk_ready,
   input  lsp_pkg::work_type wk_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [6:0]        rsp_packet_cmd,
   output logic              rsp_key_valid,
   output logic [7:0]        rsp_key_ascii,
   output logic              rsp_poll_matched,
   output logic              rsp_mode_arrived,
   output logic              rsp_pixel_arrived,
   output logic [7:0]        rsp_read_data
);
   localparam int SW = $clog2(STORE_BYTES);

   // fixed-place registers; each byte written at a fixed offset, read by one port
   logic [7:0] st_ff [STORE_BYTES];
   logic [7:0] st_in [STORE_BYTES];
   logic       screen_ff, screen_in;
   logic       vld_ff;
   logic       kind_ff, kind_in, kv_in, kv_ff, pm_in, pm_ff, ma_in, ma_ff, pa_in, pa_ff;
   logic [6:0] cmd_ff;
   logic [7:0] ka_in, ka_ff, rd_in, rd_ff;
   logic       take;
   logic [7:0] asc, vk, dn;

   assign wk_ready = !vld_ff || rsp_ready;
   assign take = wk_valid && wk_ready;

   always_comb begin
      st_in = st_ff;
      screen_in = screen_ff;
      kind_in = wk_data.is_pkt;
      kv_in = 1'b0; ka_in = '0; pm_in = 1'b0; ma_in = 1'b0; pa_in = 1'b0;
      rd_in = (int'(wk_data.roff) < STORE_BYTES) ? st_ff[wk_data.roff[SW-1:0]] : 8'd0;
      asc = wk_data.d[0]; vk = wk_data.d[2]; dn = wk_data.d[3];
      if (wk_data.is_pkt) begin
         rd_in = '0;
         case (wk_data.cmd)
            lsp_pkg::CMD_POLL:
               pm_in = (wk_data.len >= 8'd1) && (wk_data.d[0] == poll_echo);
            lsp_pkg::CMD_CURS: if (wk_data.len >= 8'd2) begin
               st_in['h07] = wk_data.d[0]; st_in['h08] = wk_data.d[1];
            end
            lsp_pkg::CMD_CHAR: if (wk_data.len >= 8'd1) begin
               st_in['h09] = wk_data.d[0];
               st_in[4] = st_ff[4] | lsp_pkg::FLAG_CHAR;
            end
            lsp_pkg::CMD_PIXEL: if (wk_data.len >= 8'd4) begin
               st_in['h0A] = wk_data.d[0]; st_in['h0B] = wk_data.d[1];
               st_in['h0C] = wk_data.d[2]; st_in['h16] = wk_data.d[3];
               st_in[4] = st_ff[4] | lsp_pkg::FLAG_PIXEL;
               pa_in = 1'b1;
            end
            lsp_pkg::CMD_AUDIO: if (wk_data.len >= 8'd1) begin
               st_in['h0D] = wk_data.d[0]; st_in['h0E] = 8'd1;
               st_in[4] = st_ff[4] | lsp_pkg::FLAG_AUDIO;
            end
            lsp_pkg::CMD_MODE: if (wk_data.len >= 8'd8) begin
               for (int i = 0; i < 4; i++) st_in['h0F + i] = wk_data.d[i];
               st_in['h13] = wk_data.d[4]; st_in['h14] = wk_data.d[5];
               st_in['h15] = wk_data.d[6]; st_in['h27] = wk_data.d[7];
               st_in[4] = st_ff[4] | lsp_pkg::FLAG_MODE;
               screen_in = 1'b1;
               ma_in = 1'b1;
            end
            lsp_pkg::CMD_CLOCK: if (wk_data.len >= 8'd6) begin
               for (int i = 0; i < 6; i++) st_in['h1A + i] = wk_data.d[i];
               st_in[4] = st_ff[4] | lsp_pkg::FLAG_CLOCK;
            end
            lsp_pkg::CMD_KBD: if (wk_data.len >= 8'd5) begin
               for (int i = 0; i < 5; i++) st_in['h20 + i] = wk_data.d[i];
            end
            lsp_pkg::CMD_KEY: if (wk_data.len >= 8'd4) begin
               st_in['h17] = vk; st_in['h18] = dn;
               st_in['h19] = st_ff['h19] + 8'd1;
               if (dn != 8'd0) begin
                  st_in['h05] = asc; st_in['h06] = wk_data.d[1];
                  if (asc == 8'd0 && (vk == lsp_pkg::VK_BS || vk == lsp_pkg::VK_DEL))
                     asc = vk;
                  kv_in = asc != 8'd0;
                  ka_in = asc;
               end else begin
                  st_in['h05] = 8'd0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_BYTES; i++) st_ff[i] <= '0;
         screen_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         if (take && wk_data.is_pkt) begin
            st_ff <= st_in;
            screen_ff <= screen_in;
         end
         if (take) vld_ff <= 1'b1;
         else if (rsp_ready) vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff <= kind_in; cmd_ff <= kind_in ? wk_data.cmd : 7'd0;
         kv_ff <= kv_in; ka_ff <= ka_in; pm_ff <= pm_in;
         ma_ff <= ma_in; pa_ff <= pa_in; rd_ff <= rd_in;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_kind = kind_ff;
   assign rsp_packet_cmd = cmd_ff;
   assign rsp_key_valid = kv_ff;
   assign rsp_key_ascii = ka_ff;
   assign rsp_poll_matched = pm_ff;
   assign rsp_mode_arrived = ma_ff;
   assign rsp_pixel_arrived = pa_ff;
   assign rsp_read_data = rd_ff;

   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !kind_ff |-> cmd_ff == 7'd0 && !kv_ff && !ma_ff && !pa_ff)
      else $error("read result carries report fields");
   a_key_ascii: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> kv_ff == (ka_ff != 8'd0)) else $error("key flag mismatch");
   a_mode_screen: assert property (@(posedge clock) disable iff (reset)
      vld_ff && ma_ff |-> screen_ff) else $error("mode without screen");
endmodule

// File: design/length_prefixed_status_packet_parser_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_status_packet_parser_core: packet parser with status store
// Parses a byte stream of length-prefixed packets into a status store and serves store reads.
// ----------------------------------------------------------------------------
// Usage: feed items on req_ (req_func 0 with req_rx_byte for a stream byte,
// 1 with req_read_offset to read a store byte). A read, or the last payload
// byte of a packet of at most MAX_PAYLOAD bytes, yields one item on rsp_; other
// bytes yield none. The user must write csr_write_data with csr_write_enable
// only while the block is idle; the block itself does not enforce this.
// An accepted item passes the parser into a two-entry queue, then the store
// update into the result register, which drives rsp_valid.
// Throughput: one item per cycle while the receiver takes responses; the store
// update applies a whole packet at once from the queued payload bytes.
// Reset clears the parser, the store, the queue and the result valid flag.
// When the receiver stalls, the result register holds, the queue fills and
// req_ready falls once both queue entries are taken.
// ----------------------------------------------------------------------------
module length_prefixed_status_packet_parser_core #(
   parameter int MAX_PAYLOAD = lsp_pkg::MaxPayloadDefault,
   parameter int STORE_BYTES = lsp_pkg::StoreBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_rx_byte,
   input  logic [5:0] req_read_offset,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [6:0] rsp_packet_cmd,
   output logic       rsp_key_valid,
   output logic [7:0] rsp_key_ascii,
   output logic       rsp_poll_matched,
   output logic       rsp_mode_arrived,
   output logic       rsp_pixel_arrived,
   output logic [7:0] rsp_read_data,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   logic [7:0] echo_ff;
   logic fw_valid, fw_ready, bw_valid, bw_ready;
   lsp_pkg::work_type fw_data, bw_data;

   always_ff @(posedge clock) begin
      if (reset) echo_ff <= '0;
      else if (csr_write_enable) echo_ff <= csr_write_data;
   end

   lsp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_rx_byte,
      .req_read_offset, .wk_valid(fw_valid), .wk_ready(fw_ready), .wk_data(fw_data));

   lsp_queue u_queue (
      .clock, .reset, .in_valid(fw_valid), .in_ready(fw_ready), .in_data(fw_data),
      .out_valid(bw_valid), .out_ready(bw_ready), .out_data(bw_data));

   lsp_back #(.STORE_BYTES(STORE_BYTES)) u_back (
      .clock, .reset, .poll_echo(echo_ff), .wk_valid(bw_valid), .wk_ready(bw_ready),
      .wk_data(bw_data), .rsp_valid, .rsp_ready, .rsp_kind, .rsp_packet_cmd,
      .rsp_key_valid, .rsp_key_ascii, .rsp_poll_matched, .rsp_mode_arrived,
      .rsp_pixel_arrived, .rsp_read_data);
endmodule

// File: tb/lsp_checker.sv
// ----------------------------------------------------------------------------
// lsp_checker: response predictor and scoreboard for the packet parser
// Watches both channels and predicts each response from a private copy of the
// parser state and status store. Compares field by field, in order.
// ----------------------------------------------------------------------------
module lsp_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_rx_byte,
   input  logic [5:0] req_read_offset,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_kind,
   input  logic [6:0] rsp_packet_cmd,
   input  logic       rsp_key_valid,
   input  logic [7:0] rsp_key_ascii,
   input  logic       rsp_poll_matched,
   input  logic       rsp_mode_arrived,
   input  logic       rsp_pixel_arrived,
   input  logic [7:0] rsp_read_data,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output int         fail_count,
   output int         pending_count
);
   localparam int PayMax = lsp_pkg::MaxPayloadDefault;

   typedef struct packed {
      logic       kind;
      logic [6:0] cmd;
      logic       kv;
      logic [7:0] ka;
      logic       pm;
      logic       ma;
      logic       pa;
      logic [7:0] rd;
   } resp_type;

   resp_type            resp_queue[$];
   lsp_pkg::phase_type  phase;
   logic [6:0] cur_cmd;
   logic [7:0] pay_len;
   logic [7:0] seen;
   logic [7:0] pay_buf [PayMax];
   logic [7:0] store [64];
   logic [7:0] echo;

   task automatic put_byte(input int off, input logic [7:0] v);
      if (off < 64) store[off] = v;
   endtask

   task automatic parse_byte(input logic [7:0] b);
      resp_type r;
      logic [7:0] asc;
      r = '0;
      case (phase)
         lsp_pkg::PH_HEADER: begin
            if (b[7]) begin
               cur_cmd = b[6:0];
               pay_len = '0;
               seen = '0;
               phase = lsp_pkg::PH_LENGTH;
            end
         end
         lsp_pkg::PH_LENGTH: begin
            pay_len = b;
            seen = '0;
            if (b == 0) phase = lsp_pkg::PH_HEADER;
            else if (b > PayMax) phase = lsp_pkg::PH_DRAIN;
            else phase = lsp_pkg::PH_DATA;
         end
         lsp_pkg::PH_DRAIN: begin
            seen = seen + 8'd1;
            if (seen >= pay_len) phase = lsp_pkg::PH_HEADER;
         end
         default: begin
            if (seen < PayMax) pay_buf[seen[3:0]] = b;
            seen = seen + 8'd1;
            if (seen >= pay_len) begin
               r.kind = 1'b1;
               r.cmd = cur_cmd;
               if (cur_cmd == lsp_pkg::CMD_POLL) begin
                  r.pm = (pay_buf[0] == echo);
               end else if (cur_cmd == lsp_pkg::CMD_CURS && pay_len >= 2) begin
                  put_byte(8'h07, pay_buf[0]);
                  put_byte(8'h08, pay_buf[1]);
               end else if (cur_cmd == lsp_pkg::CMD_CHAR) begin
                  put_byte(8'h09, pay_buf[0]);
                  store[4] |= lsp_pkg::FLAG_CHAR;
               end else if (cur_cmd == lsp_pkg::CMD_PIXEL && pay_len >= 4) begin
                  put_byte(8'h0A, pay_buf[0]);
                  put_byte(8'h0B, pay_buf[1]);
                  put_byte(8'h0C, pay_buf[2]);
                  put_byte(8'h16, pay_buf[3]);
                  store[4] |= lsp_pkg::FLAG_PIXEL;
                  r.pa = 1'b1;
               end else if (cur_cmd == lsp_pkg::CMD_AUDIO) begin
                  put_byte(8'h0D, pay_buf[0]);
                  put_byte(8'h0E, 8'h01);
                  store[4] |= lsp_pkg::FLAG_AUDIO;
               end else if (cur_cmd == lsp_pkg::CMD_MODE && pay_len >= 8) begin
                  for (int i = 0; i < 4; i++) put_byte(8'h0F + i, pay_buf[i]);
                  put_byte(8'h13, pay_buf[4]);
                  put_byte(8'h14, pay_buf[5]);
                  put_byte(8'h15, pay_buf[6]);
                  put_byte(8'h27, pay_buf[7]);
                  store[4] |= lsp_pkg::FLAG_MODE;
                  r.ma = 1'b1;
               end else if (cur_cmd == lsp_pkg::CMD_CLOCK && pay_len >= 6) begin
                  for (int i = 0; i < 6; i++) put_byte(8'h1A + i, pay_buf[i]);
                  store[4] |= lsp_pkg::FLAG_CLOCK;
               end else if (cur_cmd == lsp_pkg::CMD_KBD && pay_len >= 5) begin
                  for (int i = 0; i < 5; i++) put_byte(8'h20 + i, pay_buf[i]);
               end else if (cur_cmd == lsp_pkg::CMD_KEY && pay_len >= 4) begin
                  asc = pay_buf[0];
                  put_byte(8'h17, pay_buf[2]);
                  put_byte(8'h18, pay_buf[3]);
                  store[8'h19] = store[8'h19] + 8'd1;
                  if (pay_buf[3] != 0) begin
                     put_byte(8'h05, asc);
                     put_byte(8'h06, pay_buf[1]);
                     if (asc == 0 && (pay_buf[2] == lsp_pkg::VK_BS ||
                                      pay_buf[2] == lsp_pkg::VK_DEL))
                        asc = pay_buf[2];
                     if (asc != 0) begin
                        r.kv = 1'b1;
                        r.ka = asc;
                     end
                  end else begin
                     put_byte(8'h05, 8'h00);
                  end
               end
               phase = lsp_pkg::PH_HEADER;
               cur_cmd = '0;
               pay_len = '0;
               seen = '0;
               resp_queue.push_back(r);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      resp_type got;
      resp_type want;
      if (reset) begin
         resp_queue.delete();
         phase = lsp_pkg::PH_HEADER;
         cur_cmd = '0;
         pay_len = '0;
         seen = '0;
         echo = '0;
         for (int i = 0; i < 64; i++) store[i] = 8'h00;
         for (int i = 0; i < PayMax; i++) pay_buf[i] = 8'h00;
         fail_count <= 0;
      end else begin
         if (csr_write_enable) echo = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_packet_cmd, rsp_key_valid, rsp_key_ascii,
                   rsp_poll_matched, rsp_mode_arrived, rsp_pixel_arrived,
                   rsp_read_data};
            if (resp_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = resp_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $write("mismatch: kind %0d/%0d cmd %h/%h key %0d %h/%0d %h ",
                        want.kind, got.kind, want.cmd, got.cmd, want.kv, want.ka,
                        got.kv, got.ka);
                     $display("pm %0d/%0d ma %0d/%0d pa %0d/%0d rd %h/%h",
                        want.pm, got.pm, want.ma, got.ma,
                        want.pa, got.pa, want.rd, got.rd);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         // responses leave before the new item's prediction is queued
         if (req_valid && req_ready) begin
            if (req_func) begin
               want = '0;
               want.rd = store[req_read_offset];
               resp_queue.push_back(want);
            end else begin
               parse_byte(req_rx_byte);
            end
         end
      end
      pending_count = resp_queue.size();
   end
endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the length-prefixed status packet parser
// Drives directed and random byte streams and store reads with random idling
// and a long receiver hold-off; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module tb_top;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_func = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic [5:0] req_read_offset = 6'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_kind;
   logic [6:0] rsp_packet_cmd;
   logic       rsp_key_valid;
   logic [7:0] rsp_key_ascii;
   logic       rsp_poll_matched;
   logic       rsp_mode_arrived;
   logic       rsp_pixel_arrived;
   logic [7:0] rsp_read_data;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'h00;
   int         fail_count;
   int         pending_count;
   int         idle_cycles;
   int         items_sent = 0;
   bit         hold_off = 1'b0;
   bit         calm = 1'b0;
   bit         timed_out = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   length_prefixed_status_packet_parser_core u_top (.*);

   lsp_checker u_checker (.*);

   // receiver: random stalls, one long hold-off
   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(99) >= 31);
   end

   // watchdog on cycles with no accepted item and no taken response
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) timed_out = 1'b1;
   end

   // valid stays high after acceptance until the next item or an idle gap drops it
   task automatic send_item(input logic func, input logic [7:0] b, input logic [5:0] off);
      if (!calm) begin
         while ($urandom_range(99) < 31) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_rx_byte <= b;
      req_read_offset <= off;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(1'b0, b, 6'($urandom));
   endtask

   task automatic send_packet(input logic [6:0] cmd, input int len);
      send_byte({1'b1, cmd});
      send_byte(8'(len));
      for (int i = 0; i < len; i++) send_byte(8'($urandom));
   endtask

   task automatic send_key(input logic [7:0] asc, input logic [7:0] vk,
                           input logic [7:0] down);
      send_byte({1'b1, lsp_pkg::CMD_KEY});
      send_byte(8'd4);
      send_byte(asc);
      send_byte(8'($urandom));
      send_byte(vk);
      send_byte(down);
   endtask

   task automatic drain_and_write(input logic [7:0] v);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_packet();
      int len;
      int r;
      logic [6:0] cmd;
      r = $urandom_range(99);
      cmd = (r < 85) ? 7'($urandom_range(8)) : 7'($urandom);
      len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 16);
      if (r < 8) send_key(8'($urandom_range(3) == 0 ? 0 : $urandom),
                          ($urandom_range(1) ? lsp_pkg::VK_BS : 8'($urandom)),
                          8'($urandom_range(1)));
      else send_packet(cmd, len);
   endtask

   initial begin
      bit wrote_mid;
      bit wrote_late;
      wrote_mid = 1'b0;
      wrote_late = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      drain_and_write(8'h00);

      // directed part
      send_packet(lsp_pkg::CMD_POLL, 1);
      send_byte(8'h3C);                        // stray byte while waiting
      send_byte({1'b1, lsp_pkg::CMD_MODE}); send_byte(8'd0); // zero length
      send_byte({1'b1, lsp_pkg::CMD_CLOCK}); send_byte(8'd17);
      for (int i = 0; i < 17; i++) send_byte(8'hFF); // oversized, drained
      for (int c = 1; c <= 8; c++) send_packet(7'(c), 16);
      send_packet(lsp_pkg::CMD_MODE, 3);       // short payload
      send_packet(7'h7F, 2);                   // unknown command
      send_key(8'h00, lsp_pkg::VK_BS, 8'h01);
      send_key(8'h00, lsp_pkg::VK_DEL, 8'h01);
      send_key(8'h41, 8'h10, 8'h00);           // key up
      for (int i = 0; i < 64; i++) send_item(1'b1, 8'h00, 6'(i));

      drain_and_write(8'hFF);
      send_byte(8'h80); send_byte(8'd1); send_byte(8'hFF);
      drain_and_write(8'hA5);

      // long receiver hold-off while input keeps coming
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 10; i++) send_item(1'b1, 8'h00, 6'($urandom));
      join

      while (items_sent < 1450) begin
         if (!wrote_mid && items_sent >= 500) begin
            drain_and_write(8'($urandom));
            wrote_mid = 1'b1;
         end
         if (!wrote_late && items_sent >= 900) begin
            drain_and_write(8'h00);
            wrote_late = 1'b1;
         end
         calm = (items_sent > 600 && items_sent < 750);
         if ($urandom_range(99) < 70) begin
            random_packet();
         end else if ($urandom_range(1)) begin
            send_item(1'b1, 8'h00, 6'($urandom));
         end else begin
            send_byte(8'($urandom));
         end
         if (timed_out) break;
      end
      req_valid <= 1'b0;

      while (pending_count != 0 && !timed_out) @(posedge clock);
      repeat (10) @(posedge clock);
      if (!timed_out && fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (timed_out) begin
         $display("Verification failed");
         $finish;
      end
   end
endmodule

// File: sim.f
design/lsp_pkg.sv
design/lsp_front.sv
design/lsp_queue.sv
design/lsp_back.sv
design/length_prefixed_status_packet_parser_core.sv
tb/lsp_checker.sv
tb/tb_top.sv
